FILE: hw/rtl/sti_pkg.sv
// Shared widths, payload types and codes for the segment/triangle intersection unit.
package sti_pkg;

	// coordinate width of every register and vertex field
	localparam int COORD_BITS = 32;
	// edge and direction vectors
	localparam int DIFF_W = COORD_BITS + 1;
	// one term of a cross product
	localparam int CPROD_W = 2 * DIFF_W;
	// a full cross product component
	localparam int CROSS_W = CPROD_W + 1;
	// one term of a dot product
	localparam int DPROD_W = DIFF_W + CROSS_W;
	// a full dot product
	localparam int DOT_W = DPROD_W + 2;

	// register map
	localparam int NUM_REGS  = 6;
	localparam int ADDR_W    = 5;
	localparam int REG_IDX_W = 3;
	typedef enum logic [REG_IDX_W-1:0] {
		REG_START_X = 3'd0,
		REG_START_Y = 3'd1,
		REG_START_Z = 3'd2,
		REG_END_X   = 3'd3,
		REG_END_Y   = 3'd4,
		REG_END_Z   = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		OC_HIT       = 2'd0,
		OC_PARALLEL  = 2'd1,
		OC_OUT_SEG   = 2'd2,
		OC_OUT_TRI   = 2'd3
	} outcome_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] vert_a_x;
		logic signed [COORD_BITS-1:0] vert_a_y;
		logic signed [COORD_BITS-1:0] vert_a_z;
		logic signed [COORD_BITS-1:0] vert_b_x;
		logic signed [COORD_BITS-1:0] vert_b_y;
		logic signed [COORD_BITS-1:0] vert_b_z;
		logic signed [COORD_BITS-1:0] vert_c_x;
		logic signed [COORD_BITS-1:0] vert_c_y;
		logic signed [COORD_BITS-1:0] vert_c_z;
	} in_item_t;

	typedef struct packed {
		logic     hit;
		outcome_t outcome;
	} out_item_t;

endpackage

FILE: hw/rtl/segment_triangle_intersect_unit.sv
// Top level of the segment/triangle intersection unit: APB registers and test pipeline.
//
// channel | direction | handshake               | payload
// --------+-----------+-------------------------+-----------------------------
// in      | input     | in_valid / in_stall     | in_data  (three vertices)
// out     | output    | out_valid / out_stall   | out_data (hit, outcome)
// apb     | input     | psel, penable, pready   | paddr, pwdata, prdata
//
// One triangle enters per cycle while in_stall is low; each result leaves in order behind its item.
// Latency is set by the two chained multiplies (cross then dot), each split
// into partial products over two stages, followed by sum and compare stages.
// Each stage advances when it is empty or the next stage advances, so bubbles
// close up and a stalled output holds only the stages behind it.
// Reset clears valid bits and the segment registers to zero.
module segment_triangle_intersect_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [sti_pkg::ADDR_W-1:0]             paddr,
	input  logic [31:0]                            pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  sti_pkg::in_item_t                      in_data,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output sti_pkg::out_item_t                     out_data
);

	localparam int CB = sti_pkg::COORD_BITS;
	localparam int DW = sti_pkg::DIFF_W;
	localparam int PW = sti_pkg::CPROD_W;
	localparam int XW = sti_pkg::CROSS_W;
	localparam int MW = sti_pkg::DPROD_W;
	localparam int SW = sti_pkg::DOT_W;

	logic signed [CB-1:0] seg_q [sti_pkg::NUM_REGS];
	logic [sti_pkg::REG_IDX_W-1:0] reg_idx;

	// valid bits and stage enables
	logic v1, v2, v3, v4, v5, v6, v7, v8;
	logic en1, en2, en3, en4, en5, en6, en7, en8;

	logic signed [DW-1:0] e1_s1 [3], e2_s1 [3], d_s1 [3], tv_s1 [3];
	logic signed [DW-1:0] e1_s2 [3], e2_s2 [3], d_s2 [3], tv_s2 [3];
	logic signed [DW-1:0] e1_s3 [3], e2_s3 [3], d_s3 [3], tv_s3 [3];
	logic signed [DW-1:0] e1_s4 [3], e2_s4 [3], d_s4 [3], tv_s4 [3];
	logic signed [XW-1:0] p_s4 [3], q_s4 [3];

	logic signed [DW-1:0] cm_a [12], cm_b [12];
	logic signed [PW-1:0] cm_p [12];
	logic signed [DW-1:0] dm_a [12];
	logic signed [XW-1:0] dm_b [12];
	logic signed [MW-1:0] dm_p [12];

	logic signed [SW-1:0] det_s7, un_s7, vn_s7, tn_s7;
	logic signed [SW:0]   uv_sum;
	logic                 t_ok, tri_ok;
	sti_pkg::out_item_t   res;

	// register file
	assign reg_idx = paddr[sti_pkg::REG_IDX_W+1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sti_pkg::NUM_REGS; i++) seg_q[i] <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				sti_pkg::REG_START_X: seg_q[0] <= pwdata[CB-1:0];
				sti_pkg::REG_START_Y: seg_q[1] <= pwdata[CB-1:0];
				sti_pkg::REG_START_Z: seg_q[2] <= pwdata[CB-1:0];
				sti_pkg::REG_END_X:   seg_q[3] <= pwdata[CB-1:0];
				sti_pkg::REG_END_Y:   seg_q[4] <= pwdata[CB-1:0];
				sti_pkg::REG_END_Z:   seg_q[5] <= pwdata[CB-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			sti_pkg::REG_START_X: prdata = seg_q[0];
			sti_pkg::REG_START_Y: prdata = seg_q[1];
			sti_pkg::REG_START_Z: prdata = seg_q[2];
			sti_pkg::REG_END_X:   prdata = seg_q[3];
			sti_pkg::REG_END_Y:   prdata = seg_q[4];
			sti_pkg::REG_END_Z:   prdata = seg_q[5];
			default:              prdata = '0;
		endcase
	end

	// advance a stage when it is empty or its successor advances
	assign en8 = !v8 || !out_stall;
	assign en7 = !v7 || en8;
	assign en6 = !v6 || en7;
	assign en5 = !v5 || en6;
	assign en4 = !v4 || en5;
	assign en3 = !v3 || en4;
	assign en2 = !v2 || en3;
	assign en1 = !v1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
			v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0;
		end else begin
			if (en1) v1 <= in_valid;
			if (en2) v2 <= v1;
			if (en3) v3 <= v2;
			if (en4) v4 <= v3;
			if (en5) v5 <= v4;
			if (en6) v6 <= v5;
			if (en7) v7 <= v6;
			if (en8) v8 <= v7;
		end
	end

	// stage 1: edge, direction and offset vectors
	always_ff @(posedge clk) begin
		if (en1) begin
			e1_s1[0] <= DW'(in_data.vert_b_x) - DW'(in_data.vert_a_x);
			e1_s1[1] <= DW'(in_data.vert_b_y) - DW'(in_data.vert_a_y);
			e1_s1[2] <= DW'(in_data.vert_b_z) - DW'(in_data.vert_a_z);
			e2_s1[0] <= DW'(in_data.vert_c_x) - DW'(in_data.vert_a_x);
			e2_s1[1] <= DW'(in_data.vert_c_y) - DW'(in_data.vert_a_y);
			e2_s1[2] <= DW'(in_data.vert_c_z) - DW'(in_data.vert_a_z);
			d_s1[0]  <= DW'(seg_q[3]) - DW'(seg_q[0]);
			d_s1[1]  <= DW'(seg_q[4]) - DW'(seg_q[1]);
			d_s1[2]  <= DW'(seg_q[5]) - DW'(seg_q[2]);
			tv_s1[0] <= DW'(seg_q[0]) - DW'(in_data.vert_a_x);
			tv_s1[1] <= DW'(seg_q[1]) - DW'(in_data.vert_a_y);
			tv_s1[2] <= DW'(seg_q[2]) - DW'(in_data.vert_a_z);
		end
	end

	// carry vectors alongside the cross products
	always_ff @(posedge clk) begin
		if (en2) begin
			e1_s2 <= e1_s1; e2_s2 <= e2_s1; d_s2 <= d_s1; tv_s2 <= tv_s1;
		end
		if (en3) begin
			e1_s3 <= e1_s2; e2_s3 <= e2_s2; d_s3 <= d_s2; tv_s3 <= tv_s2;
		end
		if (en4) begin
			e1_s4 <= e1_s3; e2_s4 <= e2_s3; d_s4 <= d_s3; tv_s4 <= tv_s3;
		end
	end

	// cross product terms: p = d x e2, q = tv x e1
	always_comb begin
		cm_a[0]  = d_s1[1];  cm_b[0]  = e2_s1[2];
		cm_a[1]  = d_s1[2];  cm_b[1]  = e2_s1[1];
		cm_a[2]  = d_s1[2];  cm_b[2]  = e2_s1[0];
		cm_a[3]  = d_s1[0];  cm_b[3]  = e2_s1[2];
		cm_a[4]  = d_s1[0];  cm_b[4]  = e2_s1[1];
		cm_a[5]  = d_s1[1];  cm_b[5]  = e2_s1[0];
		cm_a[6]  = tv_s1[1]; cm_b[6]  = e1_s1[2];
		cm_a[7]  = tv_s1[2]; cm_b[7]  = e1_s1[1];
		cm_a[8]  = tv_s1[2]; cm_b[8]  = e1_s1[0];
		cm_a[9]  = tv_s1[0]; cm_b[9]  = e1_s1[2];
		cm_a[10] = tv_s1[0]; cm_b[10] = e1_s1[1];
		cm_a[11] = tv_s1[1]; cm_b[11] = e1_s1[0];
	end

	for (genvar k = 0; k < 12; k++) begin : g_cross_mul
		sti_mul #(.AW(DW), .BW(DW)) u_mul (
			.clk  (clk),
			.en_a (en2),
			.en_b (en3),
			.a    (cm_a[k]),
			.b    (cm_b[k]),
			.p    (cm_p[k])
		);
	end

	// stage 4: finish cross products
	always_ff @(posedge clk) begin
		if (en4) begin
			for (int i = 0; i < 3; i++) begin
				p_s4[i] <= XW'(cm_p[2*i]) - XW'(cm_p[2*i+1]);
				q_s4[i] <= XW'(cm_p[6+2*i]) - XW'(cm_p[6+2*i+1]);
			end
		end
	end

	// dot product terms: det = e1.p, un = tv.p, vn = d.q, tn = e2.q
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dm_a[i]   = e1_s4[i]; dm_b[i]   = p_s4[i];
			dm_a[3+i] = tv_s4[i]; dm_b[3+i] = p_s4[i];
			dm_a[6+i] = d_s4[i];  dm_b[6+i] = q_s4[i];
			dm_a[9+i] = e2_s4[i]; dm_b[9+i] = q_s4[i];
		end
	end

	for (genvar k = 0; k < 12; k++) begin : g_dot_mul
		sti_mul #(.AW(DW), .BW(XW)) u_mul (
			.clk  (clk),
			.en_a (en5),
			.en_b (en6),
			.a    (dm_a[k]),
			.b    (dm_b[k]),
			.p    (dm_p[k])
		);
	end

	// stage 7: sum dot products
	always_ff @(posedge clk) begin
		if (en7) begin
			det_s7 <= SW'(dm_p[0]) + SW'(dm_p[1]) + SW'(dm_p[2]);
			un_s7  <= SW'(dm_p[3]) + SW'(dm_p[4]) + SW'(dm_p[5]);
			vn_s7  <= SW'(dm_p[6]) + SW'(dm_p[7]) + SW'(dm_p[8]);
			tn_s7  <= SW'(dm_p[9]) + SW'(dm_p[10]) + SW'(dm_p[11]);
		end
	end

	// range checks against det, mirrored when det is negative
	always_comb begin
		uv_sum = (SW+1)'(un_s7) + (SW+1)'(vn_s7);
		if (!det_s7[SW-1]) begin
			t_ok   = !tn_s7[SW-1] && (tn_s7 <= det_s7);
			tri_ok = !un_s7[SW-1] && !vn_s7[SW-1] && (uv_sum <= (SW+1)'(det_s7));
		end else begin
			t_ok   = (tn_s7[SW-1] || (tn_s7 == '0)) && (tn_s7 >= det_s7);
			tri_ok = (un_s7[SW-1] || (un_s7 == '0)) && (vn_s7[SW-1] || (vn_s7 == '0))
				&& (uv_sum >= (SW+1)'(det_s7));
		end
		res.hit = 1'b0;
		if (det_s7 == '0) begin
			res.outcome = sti_pkg::OC_PARALLEL;
		end else if (!t_ok) begin
			res.outcome = sti_pkg::OC_OUT_SEG;
		end else if (!tri_ok) begin
			res.outcome = sti_pkg::OC_OUT_TRI;
		end else begin
			res.outcome = sti_pkg::OC_HIT;
			res.hit     = 1'b1;
		end
	end

	// stage 8: output register
	always_ff @(posedge clk) begin
		if (en8) out_data <= res;
	end

	assign out_valid = v8;

endmodule

FILE: hw/rtl/sti_mul.sv
// Two-stage signed multiplier built from four registered half-width partial products.
module sti_mul #(
	parameter int AW = 33,
	parameter int BW = 33
) (
	input  logic                     clk,
	input  logic                     en_a,
	input  logic                     en_b,
	input  logic signed [AW-1:0]     a,
	input  logic signed [BW-1:0]     b,
	output logic signed [AW+BW-1:0]  p
);

	localparam int LA = AW / 2;
	localparam int HA = AW - LA;
	localparam int LB = BW / 2;
	localparam int HB = BW - LB;
	localparam int PW = AW + BW;

	logic signed [LA:0]      a_lo;
	logic signed [HA-1:0]    a_hi;
	logic signed [LB:0]      b_lo;
	logic signed [HB-1:0]    b_hi;

	logic signed [LA+LB+1:0] pp_ll_q;
	logic signed [LA+HB:0]   pp_lh_q;
	logic signed [HA+LB:0]   pp_hl_q;
	logic signed [HA+HB-1:0] pp_hh_q;

	// split operands: low halves unsigned, high halves signed
	assign a_lo = $signed({1'b0, a[LA-1:0]});
	assign a_hi = a[AW-1:LA];
	assign b_lo = $signed({1'b0, b[LB-1:0]});
	assign b_hi = b[BW-1:LB];

	// register partial products
	always_ff @(posedge clk) begin
		if (en_a) begin
			pp_ll_q <= a_lo * b_lo;
			pp_lh_q <= a_lo * b_hi;
			pp_hl_q <= a_hi * b_lo;
			pp_hh_q <= a_hi * b_hi;
		end
	end

	// combine partial products
	always_ff @(posedge clk) begin
		if (en_b) begin
			p <= (PW'(pp_hh_q) <<< (LA + LB)) + (PW'(pp_hl_q) <<< LA)
				+ (PW'(pp_lh_q) <<< LB) + PW'(pp_ll_q);
		end
	end

endmodule
